>>> design/hpws_pkg.sv
`default_nettype none

package hpws_pkg;

   localparam int TIME_W     = 32;
   localparam int SPEED_W    = 30;
   localparam int CIRC_W     = 24;
   localparam int PPR_W      = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CIRC_W-1:0]  CIRC_RESET = 24'd197900;
   localparam logic [PPR_W-1:0]   PPR_RESET  = 5'd2;
   localparam logic [SPEED_W-1:0] SPEED_MAX  = {SPEED_W{1'b1}};

   typedef enum logic {
      REG_CIRC = 1'b0,
      REG_PPR  = 1'b1
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPAN,
      ST_MULT,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

>>> design/hpws_divider.sv
`default_nettype none

module hpws_divider #(
   parameter int NUM_W = 28,
   parameter int DEN_W = 37
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [NUM_W-1:0]      num,
   input  wire logic [DEN_W-1:0]      den,
   output logic      [NUM_W-1:0]      quotient,
   output hpws_pkg::div_status_type   status
);
   import hpws_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);

   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] rem_in;
   logic [NUM_W-1:0] quo_ff;
   logic [NUM_W-1:0] quo_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic             last_step;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   trial;

   // One restoring step per cycle: the next dividend bit enters the remainder
   // and the divisor is subtracted when it fits.
   assign shifted   = {rem_ff, quo_ff[NUM_W-1]};
   assign trial     = shifted - {1'b0, den};
   assign last_step = busy_ff && (cnt_ff == CNT_W'(NUM_W - 1));

   always_comb begin
      if (!trial[DEN_W]) begin
         rem_in = trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], 1'b1};
      end else begin
         rem_in = shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= last_step;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last_step) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

>>> design/hall_pulse_windowed_speed.sv
`default_nettype none

// Wheel speed from Hall sensor timestamps. Each request carries the millisecond
// timestamp of one sensor edge and yields one response: the speed in mm/s over
// the last WINDOW timestamps, truncated, or the all-ones speed with the zero
// span flag when the newest and oldest timestamps match. The window starts at
// zeros, so the first pulses measure against a timestamp of zero. A request
// passes through the span, multiply, divide and finish states; the restoring
// divider produces one quotient bit per cycle, and a zero span skips the
// divider. The block takes no new request until the current one is finished.
// A finished response waits in its output register while the next request is
// taken and computed; the next one finishes only once the old one is taken.
module hall_pulse_windowed_speed #(
   parameter int WINDOW = 10
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [hpws_pkg::TIME_W-1:0]        req_pulse_time_ms,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [hpws_pkg::SPEED_W-1:0]       rsp_speed_mm_s,
   output logic                                    rsp_zero_span,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [hpws_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [hpws_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [hpws_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                    pready
);
   import hpws_pkg::*;

   localparam int NUM_W = CIRC_W + $clog2(WINDOW);
   localparam int DEN_W = PPR_W + TIME_W;
   localparam logic [NUM_W-1:0] WIN_M1 = NUM_W'(WINDOW - 1);

   state_type        state_ff;
   state_type        state_in;
   logic [TIME_W-1:0] win_ff [WINDOW];
   logic [CIRC_W-1:0] circ_ff;
   logic [PPR_W-1:0]  ppr_ff;
   logic [PPR_W-1:0]  ppr_eff;
   logic [TIME_W-1:0] span_ff;
   logic              zero_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]  den_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [SPEED_W-1:0] rsp_speed_ff;
   logic              rsp_zero_ff;
   logic              accept;
   logic              csr_write;
   csr_reg_type       csr_sel;
   logic              span_load;
   logic              mult_load;
   logic              div_start;
   logic              rsp_load;
   logic [NUM_W-1:0]  quotient;
   div_status_type    div_status;

   // Configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_sel   = csr_reg_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         circ_ff <= CIRC_RESET;
         ppr_ff  <= PPR_RESET;
      end else if (csr_write) begin
         unique case (csr_sel)
            REG_CIRC: circ_ff <= pwdata[CIRC_W-1:0];
            REG_PPR:  ppr_ff  <= pwdata[PPR_W-1:0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_CIRC: prdata = CSR_DATA_W'(circ_ff);
         REG_PPR:  prdata = CSR_DATA_W'(ppr_ff);
         default:  prdata = '0;
      endcase
   end

   // Sequencer
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SPAN;
         ST_SPAN:   state_in = ST_MULT;
         ST_MULT:   state_in = (span_ff == '0) ? ST_FINISH : ST_DIVIDE;
         ST_DIVIDE: if (div_status.done) state_in = ST_FINISH;
         ST_FINISH: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      span_load = 1'b0;
      mult_load = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SPAN:   span_load = 1'b1;
         ST_MULT: begin
            mult_load = 1'b1;
            div_start = (span_ff != '0);
         end
         ST_DIVIDE: ;
         ST_FINISH: rsp_load = !rsp_valid_ff || rsp_ready;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Timestamp window, entry 0 newest
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            win_ff[i] <= '0;
         end
      end else if (accept) begin
         win_ff[0] <= req_pulse_time_ms;
         for (int i = 1; i < WINDOW; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

   assign ppr_eff = (ppr_ff == '0) ? PPR_W'(1) : ppr_ff;

   always_ff @(posedge clock) begin
      if (span_load) begin
         span_ff <= win_ff[0] - win_ff[WINDOW-1];
         num_ff  <= NUM_W'(circ_ff) * WIN_M1;
      end
      if (mult_load) begin
         zero_ff <= (span_ff == '0);
         den_ff  <= DEN_W'(ppr_eff) * DEN_W'(span_ff);
      end
   end

   hpws_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num_ff),
      .den      (den_ff),
      .quotient (quotient),
      .status   (div_status)
   );

   // Response register
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_zero_ff  <= zero_ff;
         rsp_speed_ff <= zero_ff ? SPEED_MAX : SPEED_W'(quotient);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_speed_mm_s = rsp_speed_ff;
   assign rsp_zero_span  = rsp_zero_ff;

`ifndef NO_ASSERTIONS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_SPAN)
      else $error("accepted request did not start the sequence");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide state");

   a_idle_not_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_status.busy)
      else $error("request taken while the divider is busy");

   a_zero_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_span |-> rsp_speed_mm_s == SPEED_MAX)
      else $error("zero span response is not saturated");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("response raised outside the finish state");
`endif

endmodule

`default_nettype wire
